[design/sxwf_pkg.sv]
// Shared types and constants for the system-exclusive word message framer.
package sxwf_pkg;

    localparam int NUM_CELLS = 15;

    localparam logic [2:0] TYPE_WRITE   = 3'd0;
    localparam logic [2:0] TYPE_READ    = 3'd3;
    localparam logic [2:0] TYPE_CONFIG  = 3'd4;
    localparam logic [2:0] TYPE_LIBRARY = 3'd5;

    localparam logic [7:0] SX_START = 8'hF0;
    localparam logic [7:0] SX_ZERO  = 8'h00;
    localparam logic [7:0] SX_MFR   = 8'h7F;
    localparam logic [7:0] SX_PROD  = 8'h01;
    localparam logic [7:0] SX_END   = 8'hF7;
    localparam logic [7:0] SX_MASK7 = 8'h7F;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       valid;
    } cell_t;

    function automatic cell_t make_cell(input logic [7:0] data, input logic last);
        cell_t c;
        c.data  = data;
        c.last  = last;
        c.valid = 1'b1;
        return c;
    endfunction

endpackage

[design/sxwf_cell.sv]
// One byte cell of the output shift chain.
module sxwf_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  logic            shift,
    input  sxwf_pkg::cell_t load_cell,
    input  sxwf_pkg::cell_t next_cell,
    output sxwf_pkg::cell_t cur_cell
);

    logic       valid_reg;
    logic       valid_next;
    logic       last_reg;
    logic       last_next;
    logic [7:0] data_reg;
    logic [7:0] data_next;

    always_comb
    begin
        valid_next = valid_reg;
        last_next  = last_reg;
        data_next  = data_reg;
        if (load)
        begin
            valid_next = load_cell.valid;
            last_next  = load_cell.last;
            data_next  = load_cell.data;
        end
        else if (shift)
        begin
            valid_next = next_cell.valid;
            last_next  = next_cell.last;
            data_next  = next_cell.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        data_reg <= data_next;
    end

    assign cur_cell.data  = data_reg;
    assign cur_cell.last  = last_reg;
    assign cur_cell.valid = valid_reg;

endmodule

[design/sysex_word_message_framer.sv]
// Top level: builds a system-exclusive message and shifts it out one byte per cycle while out_stall is low.
// The first byte of a message is valid in the cycle after its request transfer.
// A write message has 15 bytes, a read 12, a config or library 9; unlisted types load no bytes.
// The next request transfers in the cycle the final byte of the current message leaves the chain.
// Reset clears every cell's valid bit and sets the unit number to zero.
module sysex_word_message_framer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [3:0]  wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  req_type,
    input  logic [15:0] word_address,
    input  logic [15:0] word_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        last
);

    localparam int N = sxwf_pkg::NUM_CELLS;

    logic [3:0] unit_reg;
    logic [3:0] unit_next;

    sxwf_pkg::cell_t cells    [N];
    sxwf_pkg::cell_t load_val [N];
    sxwf_pkg::cell_t next_val [N];

    logic       load;
    logic       shift;
    logic       rest_busy;
    logic [7:0] a0, a1, a2, d0, d1, d2;
    logic [7:0] sum;
    logic [7:0] cks;

    always_comb
    begin
        unit_next = wr_en ? wr_data : unit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg <= 4'd0;
        end
        else
        begin
            unit_reg <= unit_next;
        end
    end

    always_comb
    begin
        rest_busy = 1'b0;
        for (int i = 1; i < N; i++)
        begin
            rest_busy = rest_busy | cells[i].valid;
        end
    end

    assign shift    = !cells[0].valid || !out_stall;
    assign in_stall = rest_busy || !shift;
    assign load     = in_valid && !in_stall;

    assign a0 = {4'd0, word_address[15:12]};
    assign a1 = {2'd0, word_address[11:6]};
    assign a2 = {2'd0, word_address[5:0]};
    assign d0 = {4'd0, word_data[15:12]};
    assign d1 = {2'd0, word_data[11:6]};
    assign d2 = {2'd0, word_data[5:0]};

    always_comb
    begin
        sum = {5'd0, req_type};
        if (req_type == sxwf_pkg::TYPE_WRITE || req_type == sxwf_pkg::TYPE_READ)
        begin
            sum = sum + a0 + a1 + a2;
        end
        if (req_type == sxwf_pkg::TYPE_WRITE)
        begin
            sum = sum + d0 + d1 + d2;
        end
        cks = (8'd0 - sum) & sxwf_pkg::SX_MASK7;
    end

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            load_val[i] = '0;
        end
        if (req_type == sxwf_pkg::TYPE_WRITE || req_type == sxwf_pkg::TYPE_READ ||
            req_type == sxwf_pkg::TYPE_CONFIG || req_type == sxwf_pkg::TYPE_LIBRARY)
        begin
            load_val[0] = sxwf_pkg::make_cell(sxwf_pkg::SX_START, 1'b0);
            load_val[1] = sxwf_pkg::make_cell(sxwf_pkg::SX_ZERO, 1'b0);
            load_val[2] = sxwf_pkg::make_cell(sxwf_pkg::SX_MFR, 1'b0);
            load_val[3] = sxwf_pkg::make_cell(sxwf_pkg::SX_MFR, 1'b0);
            load_val[4] = sxwf_pkg::make_cell(sxwf_pkg::SX_PROD, 1'b0);
            load_val[5] = sxwf_pkg::make_cell({4'd0, unit_reg}, 1'b0);
            load_val[6] = sxwf_pkg::make_cell({5'd0, req_type}, 1'b0);
        end
        unique case (req_type)
            sxwf_pkg::TYPE_WRITE:
            begin
                load_val[7]  = sxwf_pkg::make_cell(a0, 1'b0);
                load_val[8]  = sxwf_pkg::make_cell(a1, 1'b0);
                load_val[9]  = sxwf_pkg::make_cell(a2, 1'b0);
                load_val[10] = sxwf_pkg::make_cell(d0, 1'b0);
                load_val[11] = sxwf_pkg::make_cell(d1, 1'b0);
                load_val[12] = sxwf_pkg::make_cell(d2, 1'b0);
                load_val[13] = sxwf_pkg::make_cell(cks, 1'b0);
                load_val[14] = sxwf_pkg::make_cell(sxwf_pkg::SX_END, 1'b1);
            end
            sxwf_pkg::TYPE_READ:
            begin
                load_val[7]  = sxwf_pkg::make_cell(a0, 1'b0);
                load_val[8]  = sxwf_pkg::make_cell(a1, 1'b0);
                load_val[9]  = sxwf_pkg::make_cell(a2, 1'b0);
                load_val[10] = sxwf_pkg::make_cell(cks, 1'b0);
                load_val[11] = sxwf_pkg::make_cell(sxwf_pkg::SX_END, 1'b1);
            end
            sxwf_pkg::TYPE_CONFIG, sxwf_pkg::TYPE_LIBRARY:
            begin
                load_val[7] = sxwf_pkg::make_cell(cks, 1'b0);
                load_val[8] = sxwf_pkg::make_cell(sxwf_pkg::SX_END, 1'b1);
            end
            default:
            begin
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            if (g == N - 1)
            begin : g_tail
                assign next_val[g] = '0;
            end
            else
            begin : g_body
                assign next_val[g] = cells[g + 1];
            end
            sxwf_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .load      (load),
                .shift     (shift),
                .load_cell (load_val[g]),
                .next_cell (next_val[g]),
                .cur_cell  (cells[g])
            );
        end
    endgenerate

    assign out_valid = cells[0].valid;
    assign out_byte  = cells[0].data;
    assign last      = cells[0].last;

endmodule

[design/sxwf_checker.sv]
// Port-level assertions for the framer and the bind that attaches them.
module sxwf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [2:0]  req_type,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  out_byte,
    input logic        last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last))
        else $error("Stalled output changed.");

    a_start_byte: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall &&
        (req_type == sxwf_pkg::TYPE_WRITE || req_type == sxwf_pkg::TYPE_READ ||
         req_type == sxwf_pkg::TYPE_CONFIG || req_type == sxwf_pkg::TYPE_LIBRARY)
        |=> out_valid && out_byte == sxwf_pkg::SX_START && !last)
        else $error("Message did not open with the start byte.");

    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid)
        else $error("Gap inside a message.");

    a_accept_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> !out_valid || (last && !out_stall))
        else $error("Request taken while a message was still in progress.");

endmodule

bind sysex_word_message_framer sxwf_checker u_sxwf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last      (last)
);

[tb/tb.sv]
// Testbench for the system-exclusive word message framer: a class-based byte checker with random traffic.
module tb;

    class sysex_frame_checker;
        typedef struct packed {
            logic [7:0] value;
            logic       fin;
        } frame_byte_t;

        frame_byte_t expected_bytes[$];
        logic [3:0]  unit;
        int          errors;

        function new();
            unit   = 4'd0;
            errors = 0;
        endfunction

        function void push_byte(input logic [7:0] value, input logic fin);
            frame_byte_t b;
            b.value = value;
            b.fin   = fin;
            expected_bytes.push_back(b);
        endfunction

        function void push_word(input logic [15:0] w, inout logic [7:0] sum);
            logic [7:0] parts[3];
            parts[0] = {4'd0, w[15:12]};
            parts[1] = {2'd0, w[11:6]};
            parts[2] = {2'd0, w[5:0]};
            for (int i = 0; i < 3; i++)
            begin
                push_byte(parts[i], 1'b0);
                sum = sum + parts[i];
            end
        endfunction

        // Works out the bytes of the message that one accepted request causes.
        function void add_request(input logic [2:0] t, input logic [15:0] a,
                                  input logic [15:0] d);
            logic [7:0] sum;
            if (t != sxwf_pkg::TYPE_WRITE && t != sxwf_pkg::TYPE_READ &&
                t != sxwf_pkg::TYPE_CONFIG && t != sxwf_pkg::TYPE_LIBRARY)
                return;
            push_byte(sxwf_pkg::SX_START, 1'b0);
            push_byte(sxwf_pkg::SX_ZERO, 1'b0);
            push_byte(sxwf_pkg::SX_MFR, 1'b0);
            push_byte(sxwf_pkg::SX_MFR, 1'b0);
            push_byte(sxwf_pkg::SX_PROD, 1'b0);
            push_byte({4'd0, unit}, 1'b0);
            push_byte({5'd0, t}, 1'b0);
            sum = {5'd0, t};
            if (t == sxwf_pkg::TYPE_WRITE || t == sxwf_pkg::TYPE_READ)
                push_word(a, sum);
            if (t == sxwf_pkg::TYPE_WRITE)
                push_word(d, sum);
            push_byte((8'd0 - sum) & sxwf_pkg::SX_MASK7, 1'b0);
            push_byte(sxwf_pkg::SX_END, 1'b1);
        endfunction

        function void check_byte(input logic [7:0] value, input logic fin);
            frame_byte_t e;
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected byte %h last %b", $time, value, fin);
                errors++;
                return;
            end
            e = expected_bytes.pop_front();
            if (e.value !== value)
            begin
                $display("%0t: out_byte expected %h actual %h", $time, e.value, value);
                errors++;
            end
            if (e.fin !== fin)
            begin
                $display("%0t: last expected %b actual %b", $time, e.fin, fin);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        wr_en;
    logic [3:0]  wr_data;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  req_type;
    logic [15:0] word_address;
    logic [15:0] word_data;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_byte;
    logic        last;

    sysex_frame_checker checker_h = new();
    bit smooth;
    int hold_left;
    int stall_left;

    sysex_word_message_framer DUT (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(wr_en),
        .wr_data(wr_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .req_type(req_type),
        .word_address(word_address),
        .word_data(word_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_byte(out_byte),
        .last(last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (wr_en)
                checker_h.unit = wr_data;
            if (in_valid && !in_stall)
                checker_h.add_request(req_type, word_address, word_data);
            if (out_valid && !out_stall)
                checker_h.check_byte(out_byte, last);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (smooth || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    initial
    begin
        out_stall  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
            end
        end
    end

    task automatic send_request(input logic [2:0] t, input logic [15:0] a,
                                input logic [15:0] d);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        req_type     <= t;
        word_address <= a;
        word_data    <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (checker_h.expected_bytes.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
    endtask

    task automatic write_unit(input logic [3:0] value);
        @(negedge clk);
        wr_en   <= 1'b1;
        wr_data <= value;
        @(negedge clk);
        wr_en   <= 1'b0;
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    task automatic run_random(input int count);
        logic [2:0] t;
        int         sent;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                case ($urandom_range(0, 3))
                    0: t = sxwf_pkg::TYPE_WRITE;
                    1: t = sxwf_pkg::TYPE_READ;
                    2: t = sxwf_pkg::TYPE_CONFIG;
                    default: t = sxwf_pkg::TYPE_LIBRARY;
                endcase
                sent++;
            end
            else
            begin
                t = 3'($urandom_range(0, 7));
            end
            send_request(t, pick_word(), pick_word());
        end
    endtask

    initial
    begin
        logic [3:0] units[6];
        rst_n        = 1'b0;
        wr_en        = 1'b0;
        wr_data      = 4'd0;
        in_valid     = 1'b0;
        req_type     = sxwf_pkg::TYPE_WRITE;
        word_address = 16'd0;
        word_data    = 16'd0;
        smooth       = 1'b0;
        hold_left    = 0;
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_unit(4'd0);
        send_request(sxwf_pkg::TYPE_WRITE, 16'h0000, 16'h0000);
        send_request(sxwf_pkg::TYPE_WRITE, 16'hFFFF, 16'hFFFF);
        send_request(sxwf_pkg::TYPE_WRITE, 16'hAAAA, 16'h5555);
        send_request(sxwf_pkg::TYPE_WRITE, 16'h5555, 16'hAAAA);
        send_request(sxwf_pkg::TYPE_WRITE, 16'hF03F, 16'h0FC0);
        send_request(sxwf_pkg::TYPE_READ, 16'h0000, 16'hFFFF);
        send_request(sxwf_pkg::TYPE_READ, 16'hFFFF, 16'h0000);
        send_request(sxwf_pkg::TYPE_READ, 16'h8001, 16'h1234);
        send_request(sxwf_pkg::TYPE_CONFIG, 16'hFFFF, 16'hFFFF);
        send_request(sxwf_pkg::TYPE_CONFIG, 16'h0000, 16'h0000);
        send_request(sxwf_pkg::TYPE_LIBRARY, 16'h1234, 16'h5678);
        send_request(sxwf_pkg::TYPE_LIBRARY, 16'hFFFF, 16'h0000);
        send_request(3'd1, 16'hFFFF, 16'hFFFF);
        send_request(3'd2, 16'h0000, 16'h0000);
        send_request(3'd6, 16'h1234, 16'h4321);
        send_request(3'd7, 16'hFFFF, 16'hFFFF);
        send_request(sxwf_pkg::TYPE_WRITE, 16'h0FFF, 16'hF000);
        send_request(sxwf_pkg::TYPE_READ, 16'h0040, 16'h0000);
        wait_drained();

        units[0] = 4'd8;
        units[1] = 4'd15;
        units[2] = 4'd5;
        units[3] = 4'd0;
        units[4] = 4'd10;
        units[5] = 4'($urandom_range(0, 15));
        for (int p = 0; p < 6; p++)
        begin
            write_unit(units[p]);
            smooth = (p == 2);
            run_random(20);
            if (p == 3)
            begin
                // The receiver holds off long enough for the framer to back up its input.
                hold_left = 80;
                run_random(10);
            end
            if (p == 4)
                wait_drained();
            run_random(20);
            wait_drained();
        end

        if (checker_h.errors == 0)
            $display("[sysex_word_message_framer] OK");
        else
            $display("[sysex_word_message_framer] ERROR");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("[sysex_word_message_framer] ERROR");
        $finish;
    end

endmodule

[files.f]
design/sxwf_pkg.sv
design/sxwf_cell.sv
design/sysex_word_message_framer.sv
design/sxwf_checker.sv
tb/tb.sv
